[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every clock edge
`define MFG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define MFG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mfg_pkg.sv]
// ----------------------------------------------------------------------------
// mfg_pkg
// Constants, control structs and saturation helper of the factor gradient unit.
// ----------------------------------------------------------------------------
package mfg_pkg;

	// factor geometry
	localparam int RANK        = 16;
	localparam int MAX_VECTORS = 1024;
	localparam int STORE_DEPTH = RANK * MAX_VECTORS;
	localparam int SADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int J_W         = (RANK > 1) ? $clog2(RANK) : 1;

	// field widths
	localparam int OP_W   = 2;
	localparam int VEC_W  = 10;
	localparam int PIDX_W = 14;
	localparam int DATA_W = 32;
	localparam int ROWS_W = 11;
	localparam int LAM_W  = 16;
	localparam int CFG_W  = 16;
	localparam int CV_W   = 12;
	localparam int DC_W   = 15;

	// operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_GRAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_PRED  = 2'd2;

	// configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_REG_STRENGTH = 1'b1;

	// reset values of the configuration registers
	localparam logic [ROWS_W-1:0] ROW_COUNT_RST    = 11'd512;
	localparam logic [LAM_W-1:0]  REG_STRENGTH_RST = 16'd655;

	// tag that travels with each store read
	typedef struct packed {
		logic              valid;
		logic              dot;
		logic              col_half;
		logic              last;
		logic [PIDX_W-1:0] pidx;
	} rd_ctl_t;

	// sequencer to datapath commands
	typedef struct packed {
		logic              load;
		logic              pred_strobe;
		logic              err_strobe;
		logic              pred_emit;
		logic              err_emit;
		logic [PIDX_W-1:0] err_index;
		rd_ctl_t           rd;
	} dp_cmd_t;

	// datapath to sequencer status
	typedef struct packed {
		logic dot_done;
		logic delta_done;
	} dp_stat_t;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	// clamp a 64-bit signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/mfg_store.sv]
// ----------------------------------------------------------------------------
// mfg_store
// Factor store: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module mfg_store (
	input  logic                                clk,
	input  logic                                we,
	input  logic [mfg_pkg::SADDR_W-1:0]         waddr,
	input  logic signed [mfg_pkg::DATA_W-1:0]   wdata,
	input  logic [mfg_pkg::SADDR_W-1:0]         raddr_a,
	input  logic [mfg_pkg::SADDR_W-1:0]         raddr_b,
	output logic signed [mfg_pkg::DATA_W-1:0]   rdata_a,
	output logic signed [mfg_pkg::DATA_W-1:0]   rdata_b
);

	// contents are undefined until written; no reset
	logic signed [mfg_pkg::DATA_W-1:0] mem [mfg_pkg::STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/mfg_dp.sv]
// ----------------------------------------------------------------------------
// mfg_dp
// Multiply datapath: dot product accumulation, error term, delta stream and
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfg_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mfg_pkg::dp_cmd_t                    cmd,
	input  logic signed [mfg_pkg::DATA_W-1:0]   rating,
	input  logic [mfg_pkg::LAM_W-1:0]           reg_strength,
	input  logic signed [mfg_pkg::DATA_W-1:0]   rdata_a,
	input  logic signed [mfg_pkg::DATA_W-1:0]   rdata_b,
	output mfg_pkg::dp_stat_t                   stat,
	output logic                                result_valid,
	output logic [mfg_pkg::PIDX_W-1:0]          param_index,
	output logic signed [mfg_pkg::DATA_W-1:0]   delta_value,
	output logic signed [mfg_pkg::DATA_W-1:0]   prediction,
	output logic                                range_error,
	output logic                                last
);

	mfg_pkg::rd_ctl_t ctl_s1;
	mfg_pkg::rd_ctl_t ctl_s2;

	logic signed [mfg_pkg::DATA_W-1:0] mul_x;
	logic signed [mfg_pkg::DATA_W-1:0] mul_y;
	logic signed [mfg_pkg::DATA_W-1:0] reg_sel;
	logic signed [mfg_pkg::LAM_W:0]    lam;
	logic signed [63:0]                prod_a_s2;
	logic signed [48:0]                prod_b_s2;
	logic signed [63:0]                sh_a;
	logic signed [63:0]                sh_b;
	logic signed [63:0]                diff;
	logic signed [32:0]                err_diff;

	logic signed [63:0]                acc_q;
	logic signed [mfg_pkg::DATA_W-1:0] rating_q;
	logic signed [mfg_pkg::DATA_W-1:0] pred_q;
	logic signed [mfg_pkg::DATA_W-1:0] err_q;

	logic                              result_valid_q;
	logic [mfg_pkg::PIDX_W-1:0]        param_index_q;
	logic signed [mfg_pkg::DATA_W-1:0] delta_value_q;
	logic signed [mfg_pkg::DATA_W-1:0] prediction_q;
	logic                              range_error_q;
	logic                              last_q;

	// tag pipeline, aligned with store read data and products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= cmd.rd;
			ctl_s2 <= ctl_s1;
		end
	end

	// operand select: rdata_a is the row element, rdata_b the column element
	// dot: w*h; row half: err*h, lam*w; column half: err*w, lam*h
	assign mul_x   = ctl_s1.dot ? rdata_a : err_q;
	assign mul_y   = ctl_s1.col_half ? rdata_a : rdata_b;
	assign reg_sel = ctl_s1.col_half ? rdata_b : rdata_a;
	assign lam     = $signed({1'b0, reg_strength});

	// product stage
	always_ff @(posedge clk) begin
		prod_a_s2 <= mul_x * mul_y;
		prod_b_s2 <= lam * reg_sel;
	end

	// floor shift by 16 and combine
	assign sh_a = {{16{prod_a_s2[63]}}, prod_a_s2[63:16]};
	assign sh_b = {{31{prod_b_s2[48]}}, prod_b_s2[48:16]};
	assign diff = sh_a - sh_b;

	assign err_diff = {rating_q[mfg_pkg::DATA_W-1], rating_q}
		- {pred_q[mfg_pkg::DATA_W-1], pred_q};

	// accumulator, prediction and error terms
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q    <= '0;
			rating_q <= rating;
		end else if (ctl_s2.valid && ctl_s2.dot) begin
			acc_q <= acc_q + sh_a;
		end
		if (cmd.pred_strobe) begin
			pred_q <= mfg_pkg::sat32(acc_q);
		end
		if (cmd.err_strobe) begin
			err_q <= mfg_pkg::sat32({{31{err_diff[32]}}, err_diff});
		end
	end

	// result register: strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.err_emit || cmd.pred_emit
				|| (ctl_s2.valid && !ctl_s2.dot);
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (cmd.err_emit) begin
			param_index_q <= cmd.err_index;
			delta_value_q <= '0;
			prediction_q  <= '0;
			range_error_q <= 1'b1;
			last_q        <= 1'b1;
		end else if (cmd.pred_emit) begin
			param_index_q <= '0;
			delta_value_q <= '0;
			prediction_q  <= pred_q;
			range_error_q <= 1'b0;
			last_q        <= 1'b1;
		end else begin
			param_index_q <= ctl_s2.pidx;
			delta_value_q <= mfg_pkg::sat32(diff);
			prediction_q  <= pred_q;
			range_error_q <= 1'b0;
			last_q        <= ctl_s2.last;
		end
	end

	assign stat.dot_done   = ctl_s2.valid && ctl_s2.dot && ctl_s2.last;
	assign stat.delta_done = ctl_s2.valid && !ctl_s2.dot && ctl_s2.last;

	assign result_valid = result_valid_q;
	assign param_index  = param_index_q;
	assign delta_value  = delta_value_q;
	assign prediction   = prediction_q;
	assign range_error  = range_error_q;
	assign last         = last_q;

	// single-cycle results never collide with the delta stream
	`MFG_ASSERT_IMP(a_emit_no_stream, cmd.err_emit || cmd.pred_emit, !ctl_s1.valid && !ctl_s2.valid, "result sources collide")
	// a new item never starts while deltas are still in flight
	`MFG_ASSERT_IMP(a_load_quiet, cmd.load, !ctl_s1.valid && !ctl_s2.valid, "load during active pipeline")

endmodule

[rtl/mfg_seq.sv]
// ----------------------------------------------------------------------------
// mfg_seq
// Sequencer: accepts transactions, writes the store, steps the read addresses
// through the dot product and delta phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfg_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [mfg_pkg::OP_W-1:0]            op,
	input  logic [mfg_pkg::VEC_W-1:0]           row_index,
	input  logic [mfg_pkg::VEC_W-1:0]           col_index,
	input  logic [mfg_pkg::PIDX_W-1:0]          store_addr,
	input  logic signed [mfg_pkg::DATA_W-1:0]   store_value,
	input  logic [mfg_pkg::ROWS_W-1:0]          row_count,
	input  mfg_pkg::dp_stat_t                   stat,
	output logic                                busy,
	output mfg_pkg::dp_cmd_t                    cmd,
	output logic                                mem_we,
	output logic [mfg_pkg::SADDR_W-1:0]         mem_waddr,
	output logic signed [mfg_pkg::DATA_W-1:0]   mem_wdata,
	output logic [mfg_pkg::SADDR_W-1:0]         raddr_a,
	output logic [mfg_pkg::SADDR_W-1:0]         raddr_b
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DOT   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_PRED  = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;
	localparam logic [2:0] ST_DELTA = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;

	logic [2:0]                   state_q;
	logic [2:0]                   state_d;
	logic [mfg_pkg::J_W-1:0]      j_q;
	logic                         half_q;
	logic [mfg_pkg::OP_W-1:0]     op_q;
	logic [mfg_pkg::PIDX_W-1:0]   rbase_q;
	logic [mfg_pkg::PIDX_W-1:0]   cbase_q;

	logic                         accept;
	logic [mfg_pkg::CV_W-1:0]     cv;
	logic                         vec_bad;
	logic                         wr_ok;
	logic                         j_last;
	logic [mfg_pkg::PIDX_W-1:0]   ra;
	logic [mfg_pkg::PIDX_W-1:0]   ca;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// range checks on the incoming transaction
	assign cv      = mfg_pkg::CV_W'(row_count) + mfg_pkg::CV_W'(col_index);
	assign vec_bad = (mfg_pkg::CV_W'(row_index) >= mfg_pkg::CV_W'(mfg_pkg::MAX_VECTORS))
		|| (cv >= mfg_pkg::CV_W'(mfg_pkg::MAX_VECTORS));
	assign wr_ok   = mfg_pkg::DC_W'(store_addr) < mfg_pkg::DC_W'(mfg_pkg::STORE_DEPTH);

	// element addresses of the current step
	assign j_last  = (j_q == mfg_pkg::J_W'(mfg_pkg::RANK - 1));
	assign ra      = rbase_q + mfg_pkg::PIDX_W'(j_q);
	assign ca      = cbase_q + mfg_pkg::PIDX_W'(j_q);
	assign raddr_a = ra[mfg_pkg::SADDR_W-1:0];
	assign raddr_b = ca[mfg_pkg::SADDR_W-1:0];

	// store writes happen only while idle, so no read can overlap them
	assign mem_waddr = store_addr[mfg_pkg::SADDR_W-1:0];
	assign mem_wdata = store_value;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		mem_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						mfg_pkg::OP_WRITE: begin
							if (wr_ok) begin
								mem_we = 1'b1;
							end else begin
								cmd.err_emit  = 1'b1;
								cmd.err_index = store_addr;
							end
						end
						mfg_pkg::OP_GRAD, mfg_pkg::OP_PRED: begin
							if (vec_bad) begin
								cmd.err_emit = 1'b1;
							end else begin
								cmd.load = 1'b1;
								state_d  = ST_DOT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DOT: begin
				cmd.rd.valid = 1'b1;
				cmd.rd.dot   = 1'b1;
				cmd.rd.last  = j_last;
				cmd.rd.pidx  = ra;
				if (j_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.dot_done) begin
					state_d = ST_PRED;
				end
			end
			ST_PRED: begin
				cmd.pred_strobe = 1'b1;
				state_d         = ST_ERR;
			end
			ST_ERR: begin
				if (op_q == mfg_pkg::OP_PRED) begin
					cmd.pred_emit = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.err_strobe = 1'b1;
					state_d        = ST_DELTA;
				end
			end
			ST_DELTA: begin
				cmd.rd.valid    = 1'b1;
				cmd.rd.col_half = half_q;
				cmd.rd.last     = half_q && j_last;
				cmd.rd.pidx     = half_q ? ca : ra;
				if (half_q && j_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.delta_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step counter and vector bases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			half_q  <= 1'b0;
			op_q    <= mfg_pkg::OP_WRITE;
			rbase_q <= '0;
			cbase_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				j_q     <= '0;
				half_q  <= 1'b0;
				op_q    <= op;
				rbase_q <= mfg_pkg::PIDX_W'(row_index) * mfg_pkg::PIDX_W'(mfg_pkg::RANK);
				cbase_q <= mfg_pkg::PIDX_W'(cv) * mfg_pkg::PIDX_W'(mfg_pkg::RANK);
			end else if (cmd.rd.valid) begin
				if (j_last) begin
					j_q    <= '0;
					half_q <= (state_q == ST_DELTA) ? !half_q : 1'b0;
				end else begin
					j_q <= j_q + mfg_pkg::J_W'(1);
				end
			end
		end
	end

	// the last dot product lands only while waiting for it
	`MFG_ASSERT_IMP(a_dot_in_drain, stat.dot_done, state_q == ST_DRAIN, "dot product done out of step")
	// the last delta lands only while flushing
	`MFG_ASSERT_IMP(a_delta_in_flush, stat.delta_done, state_q == ST_FLUSH, "delta stream done out of step")
	// the column half always ends with the counter wrapped back
	`MFG_ASSERT(a_wrap_clean, (state_q != ST_FLUSH) || (!half_q && j_q == '0), "step counter not wrapped")

endmodule

[rtl/matrix_factor_gradient.sv]
// ----------------------------------------------------------------------------
// matrix_factor_gradient
// Matrix factorization SGD gradient unit over a factor store of row and
// column vectors.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. Op 0 writes one
//   store element at once and gives no result (or one flagged result if the
//   address is beyond the store); op 3 is dropped.
//   Op 2 (predict) and op 1 (gradient) read the row and column vectors, one
//   element pair per cycle through the two store read ports, and feed one
//   shared multiplier pair. Predict: one result when it is done.
//   Gradient: the 2*RANK deltas leave one per cycle, row half first, the
//   final one with last set. Out-of-range vector indexes give one flagged
//   result the cycle after the transaction.
//   Results appear for exactly one cycle with result_valid; the receiver
//   cannot stall. Configuration writes (cfg_we) are taken at any edge and
//   must only come while idle.
//   Reset clears the control state and loads row_count 512, reg_strength 655;
//   the store itself is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module matrix_factor_gradient (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [mfg_pkg::OP_W-1:0]            op,
	input  logic [mfg_pkg::VEC_W-1:0]           row_index,
	input  logic [mfg_pkg::VEC_W-1:0]           col_index,
	input  logic signed [mfg_pkg::DATA_W-1:0]   rating,
	input  logic [mfg_pkg::PIDX_W-1:0]          store_addr,
	input  logic signed [mfg_pkg::DATA_W-1:0]   store_value,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [mfg_pkg::CFG_W-1:0]           cfg_data,
	output logic                                result_valid,
	output logic [mfg_pkg::PIDX_W-1:0]          param_index,
	output logic signed [mfg_pkg::DATA_W-1:0]   delta_value,
	output logic signed [mfg_pkg::DATA_W-1:0]   prediction,
	output logic                                range_error,
	output logic                                last
);

	logic [mfg_pkg::ROWS_W-1:0]        row_count_q;
	logic [mfg_pkg::LAM_W-1:0]         reg_strength_q;

	mfg_pkg::dp_cmd_t                  cmd;
	mfg_pkg::dp_stat_t                 stat;
	logic                              mem_we;
	logic [mfg_pkg::SADDR_W-1:0]       mem_waddr;
	logic signed [mfg_pkg::DATA_W-1:0] mem_wdata;
	logic [mfg_pkg::SADDR_W-1:0]       raddr_a;
	logic [mfg_pkg::SADDR_W-1:0]       raddr_b;
	logic signed [mfg_pkg::DATA_W-1:0] rdata_a;
	logic signed [mfg_pkg::DATA_W-1:0] rdata_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= mfg_pkg::ROW_COUNT_RST;
			reg_strength_q <= mfg_pkg::REG_STRENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mfg_pkg::REG_ROW_COUNT: begin
					row_count_q <= cfg_data[mfg_pkg::ROWS_W-1:0];
				end
				mfg_pkg::REG_REG_STRENGTH: begin
					reg_strength_q <= cfg_data[mfg_pkg::LAM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mfg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.row_index   (row_index),
		.col_index   (col_index),
		.store_addr  (store_addr),
		.store_value (store_value),
		.row_count   (row_count_q),
		.stat        (stat),
		.busy        (busy),
		.cmd         (cmd),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.raddr_a     (raddr_a),
		.raddr_b     (raddr_b)
	);

	mfg_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mfg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rating       (rating),
		.reg_strength (reg_strength_q),
		.rdata_a      (rdata_a),
		.rdata_b      (rdata_b),
		.stat         (stat),
		.result_valid (result_valid),
		.param_index  (param_index),
		.delta_value  (delta_value),
		.prediction   (prediction),
		.range_error  (range_error),
		.last         (last)
	);

endmodule
